// ----- rtl/core/gray_qam_hard_demapper_macros.svh -----
// ----------------------------------------------------------------------------
// gray_qam_hard_demapper_macros.svh
// assertion macros for the hard-decision demapper, empty when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef GRAY_QAM_HARD_DEMAPPER_MACROS_SVH
`define GRAY_QAM_HARD_DEMAPPER_MACROS_SVH

`ifndef ASSERT_OFF

// implication checked on every rising edge outside reset
`define GQD_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("gqd assertion failed");

// condition that must never be seen outside reset
`define GQD_ASSERT_NEVER(lbl, ck, rn, cond) \
	lbl: assert property (@(posedge ck) disable iff (!rn) !(cond)) \
		else $error("gqd assertion failed");

`else

`define GQD_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define GQD_ASSERT_NEVER(lbl, ck, rn, cond)

`endif

`endif

// ----- rtl/core/gqd_pkg.sv -----
// ----------------------------------------------------------------------------
// gqd_pkg
// shared types, constants and level tables of the hard-decision demapper
// ----------------------------------------------------------------------------
`default_nettype none

package gqd_pkg;

	localparam int SAMPLE_WIDTH = 16;
	localparam int FRAC_BITS    = 13;

	// 1/sqrt(10) and 1/sqrt(42) as unsigned q0.32, rounded to nearest
	localparam logic [63:0] INV_SQRT10_Q32 = 64'd1358187913;
	localparam logic [63:0] INV_SQRT42_Q32 = 64'd662727842;

	localparam int CODE_W    = 3;
	localparam int NCAND     = 1 << CODE_W;
	localparam int PATTERN_W = 2 * CODE_W;
	localparam int COUNT_W   = 3;

	typedef enum logic [1:0] {
		MODE_BPSK  = 2'd0,
		MODE_QPSK  = 2'd1,
		MODE_QAM16 = 2'd2,
		MODE_QAM64 = 2'd3
	} mode_t;

	// one candidate point of an axis
	typedef struct packed {
		logic                           en;
		logic [SAMPLE_WIDTH-1:0]        delta;
		logic [CODE_W-1:0]              code;
		logic signed [SAMPLE_WIDTH-1:0] level;
	} cand_t;

	// bits per symbol
	function automatic logic [COUNT_W-1:0] count_of(input mode_t m);
		logic [COUNT_W-1:0] r;
		unique case (m)
			MODE_BPSK:  r = COUNT_W'(1);
			MODE_QPSK:  r = COUNT_W'(2);
			MODE_QAM16: r = COUNT_W'(4);
			MODE_QAM64: r = COUNT_W'(6);
			default:    r = COUNT_W'(1);
		endcase
		return r;
	endfunction

	// gray code to odd level index k, per axis bit count
	function automatic int odd_of_code(input int code, input int nbits);
		int k;
		k = 0;
		if (nbits == 1) begin
			k = ((code & 1) != 0) ? 1 : -1;
		end else if (nbits == 2) begin
			case (code & 3)
				0:       k = -3;
				1:       k = -1;
				2:       k = 3;
				default: k = 1;
			endcase
		end else begin
			case (code & 7)
				0:       k = -7;
				1:       k = -5;
				2:       k = -1;
				3:       k = -3;
				4:       k = 7;
				5:       k = 5;
				6:       k = 1;
				default: k = 3;
			endcase
		end
		return k;
	endfunction

	// level of a code in a mode, saturated to the sample range; elaboration only
	function automatic logic signed [SAMPLE_WIDTH-1:0] level_calc(input int mode,
			input int code);
		int          nb;
		int          k;
		logic [63:0] mag;
		logic [63:0] v;
		longint      sv;
		longint      hi;
		longint      lo;
		nb  = (mode < 2) ? 1 : ((mode == 2) ? 2 : 3);
		k   = odd_of_code(code, nb);
		mag = 64'(k < 0 ? -k : k);
		if (mode < 2) begin
			v = mag << FRAC_BITS;
		end else begin
			v = (mag * ((mode == 2) ? INV_SQRT10_Q32 : INV_SQRT42_Q32)
				+ (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
		end
		sv = (k < 0) ? -longint'(v) : longint'(v);
		hi = (longint'(1) <<< (SAMPLE_WIDTH - 1)) - 1;
		lo = -hi - 1;
		if (sv > hi) sv = hi;
		if (sv < lo) sv = lo;
		return SAMPLE_WIDTH'(sv);
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/gray_qam_hard_demapper.sv -----
// ----------------------------------------------------------------------------
// gray_qam_hard_demapper
// gray-coded bpsk / qpsk / 16-qam / 64-qam hard-decision demapper
// ----------------------------------------------------------------------------
//
//  channel   ports                                    transfer when
//  -------   --------------------------------------   --------------------------
//  sample    start, busy, rx_i, rx_q                  start high, busy low
//  result    done, symbol_bits, bit_count,            every cycle done is high
//            hard_i, hard_q
//  config    cfg_valid, cfg_ready, cfg_data           cfg_valid and cfg_ready high
//
//  one sample per clock cycle, sustained; busy never rises
//  pipeline stages: input capture, distance, pair compare, final compare
//  the four-stage pipeline sets the rate, each axis has its own tree
//  reset clears the stage valid bits and sets the mode to bpsk
//  the result is shown for one cycle only, the receiver cannot stall it
//
`default_nettype none

module gray_qam_hard_demapper (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	output logic                                    busy,
	input  logic signed [gqd_pkg::SAMPLE_WIDTH-1:0] rx_i,
	input  logic signed [gqd_pkg::SAMPLE_WIDTH-1:0] rx_q,
	output logic                                    done,
	output logic [gqd_pkg::PATTERN_W-1:0]           symbol_bits,
	output logic [gqd_pkg::COUNT_W-1:0]             bit_count,
	output logic signed [gqd_pkg::SAMPLE_WIDTH-1:0] hard_i,
	output logic signed [gqd_pkg::SAMPLE_WIDTH-1:0] hard_q,
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [1:0]                              cfg_data
);
	import gqd_pkg::*;

`include "gray_qam_hard_demapper_macros.svh"

	// modulation register, always ready for a transfer
	mode_t mode_q;

	// stage valid bits travel alongside the payload
	logic valid_s1;
	logic valid_s2;
	logic valid_s3;
	logic valid_s4;

	// mode follows its sample down the pipe
	mode_t mode_s1;
	mode_t mode_s2;
	mode_t mode_s3;
	mode_t mode_s4;

	logic signed [SAMPLE_WIDTH-1:0] rx_i_s1;
	logic signed [SAMPLE_WIDTH-1:0] rx_q_s1;

	cand_t cand_i_s2 [NCAND];
	cand_t cand_q_s2 [NCAND];

	logic [CODE_W-1:0]              code_i_s4;
	logic [CODE_W-1:0]              code_q_s4;
	logic signed [SAMPLE_WIDTH-1:0] level_i_s4;
	logic signed [SAMPLE_WIDTH-1:0] level_q_s4;

	logic accept;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_BPSK;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= mode_t'(cfg_data);
		end
	end

	// control: valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// payload: no reset needed, qualified by the valid bits
	always_ff @(posedge clk) begin
		if (accept) begin
			rx_i_s1 <= rx_i;
			rx_q_s1 <= rx_q;
			mode_s1 <= mode_q;
		end
		mode_s2 <= mode_s1;
		mode_s3 <= mode_s2;
		mode_s4 <= mode_s3;
	end

	// per-axis distances, stage 2
	gqd_axis_dist u_dist_i (
		.clk     (clk),
		.mode    (mode_s1),
		.sample  (rx_i_s1),
		.cand_s2 (cand_i_s2)
	);

	gqd_axis_dist u_dist_q (
		.clk     (clk),
		.mode    (mode_s1),
		.sample  (rx_q_s1),
		.cand_s2 (cand_q_s2)
	);

	// per-axis nearest level, stages 3 and 4
	gqd_axis_min u_min_i (
		.clk      (clk),
		.cand_s2  (cand_i_s2),
		.code_s4  (code_i_s4),
		.level_s4 (level_i_s4)
	);

	gqd_axis_min u_min_q (
		.clk      (clk),
		.cand_s2  (cand_q_s2),
		.code_s4  (code_q_s4),
		.level_s4 (level_q_s4)
	);

	// result packing: i bits above q bits, right-aligned, first bit of the symbol at the top of the used bits
	always_comb begin
		unique case (mode_s4)
			MODE_BPSK:  symbol_bits = {(PATTERN_W-1)'(0), code_i_s4[0]};
			MODE_QPSK:  symbol_bits = {(PATTERN_W-2)'(0), code_i_s4[0], code_q_s4[0]};
			MODE_QAM16: symbol_bits = {(PATTERN_W-4)'(0), code_i_s4[1:0], code_q_s4[1:0]};
			MODE_QAM64: symbol_bits = {code_i_s4, code_q_s4};
			default:    symbol_bits = {(PATTERN_W-1)'(0), code_i_s4[0]};
		endcase
	end

	// bpsk decides on i alone, q point is zero
	assign bit_count = count_of(mode_s4);
	assign hard_i    = level_i_s4;
	assign hard_q    = (mode_s4 == MODE_BPSK) ? '0 : level_q_s4;
	assign done      = valid_s4;

	// every accepted sample gives exactly one result at the end of the pipeline
	`GQD_ASSERT_NEVER(a_one_result, clk, arst_n, $past(arst_n, 4) && (done != $past(accept, 4)))
	// the result carries the mode that was set when its sample was taken
	`GQD_ASSERT_IMP(a_mode_follows, clk, arst_n, done, bit_count == count_of($past(mode_q, 4)))
	// bpsk results keep one bit and a zero quadrature point
	`GQD_ASSERT_IMP(a_bpsk_shape, clk, arst_n, done && (bit_count == count_of(MODE_BPSK)), (hard_q == '0) && (symbol_bits[PATTERN_W-1:1] == '0))

endmodule

`default_nettype wire

// ----- rtl/core/gqd_axis_dist.sv -----
// ----------------------------------------------------------------------------
// gqd_axis_dist
// distance stage: absolute distance from one axis sample to every level
// ----------------------------------------------------------------------------
`default_nettype none

module gqd_axis_dist (
	input  logic                                  clk,
	input  gqd_pkg::mode_t                        mode,
	input  logic signed [gqd_pkg::SAMPLE_WIDTH-1:0] sample,
	output gqd_pkg::cand_t                        cand_s2 [gqd_pkg::NCAND]
);
	import gqd_pkg::*;

	for (genvar c = 0; c < NCAND; c++) begin : g_cand
		localparam logic signed [SAMPLE_WIDTH-1:0] LVL_BPSK = (c < 2) ? level_calc(0, c) : '0;
		localparam logic signed [SAMPLE_WIDTH-1:0] LVL_QPSK = (c < 2) ? level_calc(1, c) : '0;
		localparam logic signed [SAMPLE_WIDTH-1:0] LVL_Q16  = (c < 4) ? level_calc(2, c) : '0;
		localparam logic signed [SAMPLE_WIDTH-1:0] LVL_Q64  = level_calc(3, c);
		localparam logic EN_SMALL = (c < 2);
		localparam logic EN_Q16   = (c < 4);

		logic signed [SAMPLE_WIDTH-1:0] lvl;
		logic                           en;
		logic [SAMPLE_WIDTH:0]          diff;
		logic [SAMPLE_WIDTH:0]          absd;

		always_comb begin
			unique case (mode)
				MODE_BPSK: begin
					lvl = LVL_BPSK;
					en  = EN_SMALL;
				end
				MODE_QPSK: begin
					lvl = LVL_QPSK;
					en  = EN_SMALL;
				end
				MODE_QAM16: begin
					lvl = LVL_Q16;
					en  = EN_Q16;
				end
				MODE_QAM64: begin
					lvl = LVL_Q64;
					en  = 1'b1;
				end
				default: begin
					lvl = LVL_BPSK;
					en  = EN_SMALL;
				end
			endcase
		end

		// sign-extended difference, then magnitude (always below 2^SAMPLE_WIDTH)
		assign diff = {sample[SAMPLE_WIDTH-1], sample} - {lvl[SAMPLE_WIDTH-1], lvl};
		assign absd = diff[SAMPLE_WIDTH] ? (SAMPLE_WIDTH+1)'(-diff) : diff;

		always_ff @(posedge clk) begin
			cand_s2[c].en    <= en;
			cand_s2[c].delta <= absd[SAMPLE_WIDTH-1:0];
			cand_s2[c].code  <= CODE_W'(c);
			cand_s2[c].level <= lvl;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/gqd_axis_min.sv -----
// ----------------------------------------------------------------------------
// gqd_axis_min
// registered compare tree: nearest enabled candidate, lower code wins ties
// ----------------------------------------------------------------------------
`default_nettype none

module gqd_axis_min (
	input  logic                                    clk,
	input  gqd_pkg::cand_t                          cand_s2 [gqd_pkg::NCAND],
	output logic [gqd_pkg::CODE_W-1:0]              code_s4,
	output logic signed [gqd_pkg::SAMPLE_WIDTH-1:0] level_s4
);
	import gqd_pkg::*;

	localparam int HALF = NCAND / 2;

	// b replaces a only when strictly nearer; a always holds the lower codes
	function automatic cand_t pick(input cand_t a, input cand_t b);
		return (b.en && (!a.en || (b.delta < a.delta))) ? b : a;
	endfunction

	cand_t win_s3 [HALF];
	cand_t w_lo;
	cand_t w_hi;
	cand_t w_fin;

	for (genvar i = 0; i < HALF; i++) begin : g_pair
		always_ff @(posedge clk) begin
			win_s3[i] <= pick(cand_s2[2*i], cand_s2[2*i+1]);
		end
	end

	always_comb begin
		w_lo  = pick(win_s3[0], win_s3[1]);
		w_hi  = pick(win_s3[2], win_s3[3]);
		w_fin = pick(w_lo, w_hi);
	end

	always_ff @(posedge clk) begin
		code_s4  <= w_fin.code;
		level_s4 <= w_fin.level;
	end

endmodule

`default_nettype wire
